// File: hw/rtl/minv_pkg.sv
// Shared types and constants for the 3x3 matrix inverse block.
// Holds the item structs, the datapath widths and the pipeline depths.
// No dependencies.
package minv_pkg;

  localparam int IN_W       = 16;
  localparam int FRAC       = 8;
  localparam int OUT_FRAC   = 16;
  localparam int OUT_W      = 32;
  localparam int PROD_W     = 2 * IN_W;
  localparam int COF_W      = PROD_W + 1;
  localparam int DPROD_W    = IN_W + COF_W;
  localparam int DET_W      = DPROD_W + 2;
  localparam int SHIFT      = FRAC + OUT_FRAC + 1;
  localparam int NUM_W      = COF_W + SHIFT;
  localparam int D2_W       = DET_W + 1;
  localparam int Q_W        = OUT_W;
  localparam int DIV_STAGES = 16;
  localparam int DIV_BITS   = Q_W / DIV_STAGES;

  // Stage indexes of the whole pipeline
  localparam int ST_DET     = 1;
  localparam int ST_LANE    = 5;
  localparam int ST_LAST    = ST_LANE + DIV_STAGES;
  localparam int ST_OUT     = ST_LAST + 1;
  localparam int NUM_STAGES = ST_OUT + 1;

  localparam logic [Q_W-1:0] LIM_POS = Q_W'(32'h7FFF_FFFF);
  localparam logic [Q_W-1:0] LIM_NEG = Q_W'(32'h8000_0000);

  typedef logic signed [IN_W-1:0]  entry_t;
  typedef logic signed [COF_W-1:0] cof_t;
  typedef logic signed [DET_W-1:0] det_t;

  typedef struct packed {
    logic signed [IN_W-1:0] a_r0c0;
    logic signed [IN_W-1:0] a_r0c1;
    logic signed [IN_W-1:0] a_r0c2;
    logic signed [IN_W-1:0] a_r1c0;
    logic signed [IN_W-1:0] a_r1c1;
    logic signed [IN_W-1:0] a_r1c2;
    logic signed [IN_W-1:0] a_r2c0;
    logic signed [IN_W-1:0] a_r2c1;
    logic signed [IN_W-1:0] a_r2c2;
  } mat_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] inv_r0c0;
    logic signed [OUT_W-1:0] inv_r0c1;
    logic signed [OUT_W-1:0] inv_r0c2;
    logic signed [OUT_W-1:0] inv_r1c0;
    logic signed [OUT_W-1:0] inv_r1c1;
    logic signed [OUT_W-1:0] inv_r1c2;
    logic signed [OUT_W-1:0] inv_r2c0;
    logic signed [OUT_W-1:0] inv_r2c1;
    logic signed [OUT_W-1:0] inv_r2c2;
    logic                    singular;
    logic                    saturated;
  } inv_item_t;

  // Result of one lane at the end of its divider
  typedef struct packed {
    logic [Q_W-1:0] q;
    logic           ovf;
    logic           neg;
  } lane_res_t;

  // Row or column left over when index i is removed; k picks the first or second
  function automatic logic [1:0] other_idx(input int i, input int k);
    logic [1:0] r;
    if (k == 0) begin
      r = (i == 0) ? 2'd1 : 2'd0;
    end else begin
      r = (i == 2) ? 2'd1 : 2'd2;
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/minv_det.sv
// Cofactor and determinant front end: minor products, signed cofactors,
// expansion along column 0 and the determinant sum. Four pipeline stages.
// Depends on minv_pkg.
module minv_det (
  input  logic                  clk,
  input  logic [3:0]            en,
  input  minv_pkg::mat_item_t   mat,
  output minv_pkg::det_t        det,
  output minv_pkg::cof_t [8:0]  cof
);
  import minv_pkg::*;

  logic [9*IN_W-1:0] flat;
  entry_t a [3][3];

  logic signed [PROD_W-1:0]  pa [3][3];
  logic signed [PROD_W-1:0]  pb [3][3];
  entry_t                    col1 [3];
  entry_t                    col2 [3];
  cof_t                      cof2 [3][3];
  logic signed [DPROD_W-1:0] dp [3];
  cof_t                      cof3 [3][3];
  det_t                      det4;
  cof_t                      cof4 [3][3];

  // Unpack the item, first field is row 0 column 0
  assign flat = mat;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        a[i][j] = entry_t'(flat[(8 - (i * 3 + j)) * IN_W +: IN_W]);
      end
    end
  end

  always_ff @(posedge clk) begin
    // Minor products
    if (en[0]) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          pa[i][j] <= a[other_idx(i, 0)][other_idx(j, 0)] * a[other_idx(i, 1)][other_idx(j, 1)];
          pb[i][j] <= a[other_idx(i, 0)][other_idx(j, 1)] * a[other_idx(i, 1)][other_idx(j, 0)];
        end
        col1[i] <= a[i][0];
      end
    end
    // Signed cofactors
    if (en[1]) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          if (((i + j) % 2) == 1) begin
            cof2[i][j] <= COF_W'(pb[i][j]) - COF_W'(pa[i][j]);
          end else begin
            cof2[i][j] <= COF_W'(pa[i][j]) - COF_W'(pb[i][j]);
          end
        end
        col2[i] <= col1[i];
      end
    end
    // Column 0 expansion products
    if (en[2]) begin
      for (int i = 0; i < 3; i++) begin
        dp[i] <= DPROD_W'(col2[i]) * DPROD_W'(cof2[i][0]);
      end
      cof3 <= cof2;
    end
    // Determinant sum
    if (en[3]) begin
      det4 <= DET_W'(dp[0]) + DET_W'(dp[1]) + DET_W'(dp[2]);
      cof4 <= cof3;
    end
  end

  assign det = det4;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        cof[i * 3 + j] = cof4[i][j];
      end
    end
  end

endmodule

// File: hw/rtl/minv_lane.sv
// One inverse lane: rounds and scales one cofactor over the determinant
// with a pipelined restoring divider, two quotient bits per stage.
// Depends on minv_pkg.
module minv_lane (
  input  logic                      clk,
  input  logic [minv_pkg::DIV_STAGES:0] en,
  input  minv_pkg::det_t            det,
  input  minv_pkg::cof_t            cof,
  output minv_pkg::lane_res_t       res
);
  import minv_pkg::*;

  logic             det_neg;
  logic [DET_W-1:0] dmag;
  logic [COF_W-1:0] cmag;
  logic [NUM_W-1:0] num;

  logic [D2_W-1:0] rem  [DIV_STAGES+1];
  logic [Q_W-1:0]  qn   [DIV_STAGES+1];
  logic [D2_W-1:0] d2   [DIV_STAGES+1];
  logic            ovf  [DIV_STAGES+1];
  logic            neg  [DIV_STAGES+1];
  logic [D2_W-1:0] rem_next [DIV_STAGES];
  logic [Q_W-1:0]  qn_next  [DIV_STAGES];

  // Magnitudes and rounded numerator: |c| * 2^SHIFT + |det|, divided by 2|det|
  always_comb begin
    det_neg = det[DET_W-1];
    dmag    = det_neg ? DET_W'(-det) : DET_W'(det);
    cmag    = cof[COF_W-1] ? COF_W'(-cof) : COF_W'(cof);
    num     = (NUM_W'(cmag) << SHIFT) + NUM_W'(dmag);
  end

  // Two restoring steps per stage; quotient bits shift in as numerator bits shift out
  always_comb begin
    logic [D2_W-1:0] r;
    logic [Q_W-1:0]  q;
    logic [D2_W:0]   t;
    for (int s = 0; s < DIV_STAGES; s++) begin
      r = rem[s];
      q = qn[s];
      for (int b = 0; b < DIV_BITS; b++) begin
        t = {r, q[Q_W-1]};
        q = {q[Q_W-2:0], 1'b0};
        if (t >= {1'b0, d2[s]}) begin
          t    = t - {1'b0, d2[s]};
          q[0] = 1'b1;
        end
        r = t[D2_W-1:0];
      end
      rem_next[s] = r;
      qn_next[s]  = q;
    end
  end

  always_ff @(posedge clk) begin
    // Prepare divider operands and detect quotient overflow
    if (en[0]) begin
      rem[0] <= D2_W'(num[NUM_W-1:Q_W]);
      qn[0]  <= num[Q_W-1:0];
      d2[0]  <= {dmag, 1'b0};
      ovf[0] <= D2_W'(num[NUM_W-1:Q_W]) >= {dmag, 1'b0};
      neg[0] <= cof[COF_W-1] ^ det_neg;
    end
    // Advance divider stages
    for (int s = 1; s <= DIV_STAGES; s++) begin
      if (en[s]) begin
        rem[s] <= rem_next[s-1];
        qn[s]  <= qn_next[s-1];
        d2[s]  <= d2[s-1];
        ovf[s] <= ovf[s-1];
        neg[s] <= neg[s-1];
      end
    end
  end

  assign res.q   = qn[DIV_STAGES];
  assign res.ovf = ovf[DIV_STAGES];
  assign res.neg = neg[DIV_STAGES];

endmodule

// File: hw/rtl/matrix_inverse_3x3.sv
// 3x3 matrix inverse by the adjugate method: Q8.8 entries in, saturated Q16.16
// inverse entries out, with singular and saturated flags. One matrix item
// enters every clock cycle while mat_stall is low. The stages are the input
// register, the four-stage cofactor and determinant front end, an operand
// stage, the sixteen-stage divider of each of the nine lanes (two quotient
// bits per stage), and the merging output register. Stall propagates back stage
// by stage, so empty stages keep filling while a result waits on the output.
module matrix_inverse_3x3 (
  input  logic                clk,
  input  logic                rst,
  input  logic                mat_valid,
  output logic                mat_stall,
  input  minv_pkg::mat_item_t mat,
  output logic                inv_valid,
  input  logic                inv_stall,
  output minv_pkg::inv_item_t inv
);
  import minv_pkg::*;

  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES:0]   ready;
  logic [NUM_STAGES-1:0] en;

  mat_item_t  mat_reg;
  det_t       det;
  cof_t [8:0] cof;
  lane_res_t  res [9];
  logic       sing [ST_LANE:ST_LAST];

  logic [OUT_W-1:0] val [9];
  logic [8:0]       sat_lane;
  logic [9*OUT_W-1:0] vals_flat;

  // Stage handshake: a stage loads when it is empty or its successor moves
  always_comb begin
    ready[NUM_STAGES] = !inv_stall;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      ready[k] = !vld[k] || ready[k+1];
    end
    en = ready[NUM_STAGES-1:0];
  end

  assign mat_stall = !ready[0];
  assign inv_valid = vld[ST_OUT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= mat_valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Capture input item
  always_ff @(posedge clk) begin
    if (en[0]) begin
      mat_reg <= mat;
    end
  end

  minv_det u_det (
    .clk (clk),
    .en  (en[ST_DET +: 4]),
    .mat (mat_reg),
    .det (det),
    .cof (cof)
  );

  // Inverse entry (r,c) takes cofactor (c,r)
  for (genvar g = 0; g < 9; g++) begin : g_lane
    minv_lane u_lane (
      .clk (clk),
      .en  (en[ST_LANE +: DIV_STAGES + 1]),
      .det (det),
      .cof (cof[(g % 3) * 3 + (g / 3)]),
      .res (res[g])
    );
  end

  // Carry the singular flag alongside the lanes
  always_ff @(posedge clk) begin
    if (en[ST_LANE]) begin
      sing[ST_LANE] <= (det == '0);
    end
    for (int k = ST_LANE + 1; k <= ST_LAST; k++) begin
      if (en[k]) begin
        sing[k] <= sing[k-1];
      end
    end
  end

  // Merge lanes: clip, restore sign, force zero when singular
  always_comb begin
    logic [Q_W-1:0] lim;
    logic [Q_W-1:0] mag;
    for (int g = 0; g < 9; g++) begin
      lim         = res[g].neg ? LIM_NEG : LIM_POS;
      sat_lane[g] = res[g].ovf || (res[g].q > lim);
      mag         = sat_lane[g] ? lim : res[g].q;
      val[g]      = sing[ST_LAST] ? '0 : (res[g].neg ? OUT_W'(-mag) : OUT_W'(mag));
      vals_flat[(8 - g) * OUT_W +: OUT_W] = val[g];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      inv <= {vals_flat, sing[ST_LAST], !sing[ST_LAST] && (|sat_lane)};
    end
  end

endmodule
